// ----- sv/lbt_pkg.sv -----
// Shared status codes, register indexes and constants of the listen-before-talk gate.
`default_nettype none
package lbt_pkg;

  // Result status codes
  localparam logic [2:0] ST_CLEAR    = 3'd0;
  localparam logic [2:0] ST_BUSY     = 3'd1;
  localparam logic [2:0] ST_BACKOFF  = 3'd2;
  localparam logic [2:0] ST_ERROR    = 3'd3;
  localparam logic [2:0] ST_DISABLED = 3'd4;
  localparam logic [2:0] ST_QUERY    = 3'd5;

  // Command codes
  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  // Carrier-detect outcome codes
  localparam logic [1:0] CAD_CLEAR    = 2'd0;
  localparam logic [1:0] CAD_DETECTED = 2'd1;
  localparam logic [1:0] CAD_ERROR    = 2'd2;
  localparam logic [1:0] CAD_TIMEOUT  = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] REG_LBT_ENABLE  = 8'd0;
  localparam logic [7:0] REG_RSSI_LIMIT  = 8'd1;
  localparam logic [7:0] REG_BACKOFF_CAP = 8'd2;
  localparam logic [7:0] REG_DETECT_LEN  = 8'd3;

  // Backoff and signal-strength constants
  localparam logic [15:0] BASE_BACKOFF_MS = 16'd10;
  localparam logic [2:0]  MAX_SHIFT       = 3'd6;
  localparam logic [7:0]  ATTEMPT_LIMIT   = 8'hFF;
  localparam logic [9:0]  RSSI_OFFSET     = 10'd157;

  // Register reset values
  localparam logic        RESET_LBT_ENABLE  = 1'b1;
  localparam logic [7:0]  RESET_THRESHOLD   = 8'hA6;
  localparam logic [15:0] RESET_MAX_BACKOFF = 16'd500;
  localparam logic [7:0]  RESET_CAD_SYMBOLS = 8'd4;

endpackage
`default_nettype wire

// ----- sv/listen_before_talk_backoff.sv -----
// Listen-before-talk channel-access gate with exponential backoff.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   command now_ms cad_outcome rx_entry_ok rssi_raw
//   out      source     out_valid/out_stall status backoff_remaining_ms tx_abort
//   cfg      sink       cfg_valid/cfg_ready cfg_index cfg_data
//
// An accepted transaction is captured in the input register and then passes the decision logic
// into the result register, where its result is shown with out_valid.
// With no stall one transaction is accepted every cycle.
// Backoff state is updated as an item moves into the result register, so the next item
// sees it. Reset clears the state, the pipeline and the registers to their defaults.
// A stalled result holds the result register; once the input register is also full it
// holds too and in_stall rises.
`default_nettype none
module listen_before_talk_backoff (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [31:0] now_ms,
  input  wire logic [1:0]  cad_outcome,
  input  wire logic        rx_entry_ok,
  input  wire logic [7:0]  rssi_raw,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       status,
  output logic [15:0]      backoff_remaining_ms,
  output logic             tx_abort,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers
  logic        lbt_enable;
  logic [7:0]  rssi_limit;
  logic [15:0] backoff_cap;
  logic [7:0]  detect_len;

  // Backoff state
  logic [31:0] backoff_deadline;
  logic [7:0]  attempt_count;
  logic        backoff_armed;
  logic [31:0] backoff_deadline_next;
  logic [7:0]  attempt_count_next;
  logic        backoff_armed_next;

  // Input register
  logic        s1_valid;
  logic        s1_command;
  logic [31:0] s1_now;
  logic [1:0]  s1_cad;
  logic        s1_rx_ok;
  logic [7:0]  s1_rssi;

  // Decision signals
  logic        s1_move;
  logic [31:0] diff_fwd;
  logic [31:0] diff_back;
  logic [15:0] rem_old;
  logic [2:0]  shift;
  logic [15:0] len_raw;
  logic [15:0] len;
  logic signed [9:0] rssi_level;
  logic signed [9:0] thr;
  logic        rssi_busy;
  logic        busy;
  logic [2:0]  status_next;
  logic [15:0] remaining_next;
  logic        abort_next;

  assign cfg_ready = 1'b1;

  // Move the input register on when the result register is free or being taken
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lbt_enable  <= lbt_pkg::RESET_LBT_ENABLE;
      rssi_limit  <= lbt_pkg::RESET_THRESHOLD;
      backoff_cap <= lbt_pkg::RESET_MAX_BACKOFF;
      detect_len  <= lbt_pkg::RESET_CAD_SYMBOLS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbt_pkg::REG_LBT_ENABLE:  lbt_enable  <= cfg_data[0];
        lbt_pkg::REG_RSSI_LIMIT:  rssi_limit  <= cfg_data[7:0];
        lbt_pkg::REG_BACKOFF_CAP: backoff_cap <= cfg_data;
        lbt_pkg::REG_DETECT_LEN:  detect_len  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Capture an accepted transaction into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_command <= command;
      s1_now     <= now_ms;
      s1_cad     <= cad_outcome;
      s1_rx_ok   <= rx_entry_ok;
      s1_rssi    <= rssi_raw;
    end
  end

  // Remaining backoff under the current state
  assign diff_fwd  = s1_now - backoff_deadline;
  assign diff_back = backoff_deadline - s1_now;
  always_comb begin
    if (!backoff_armed || !diff_fwd[31]) begin
      rem_old = 16'd0;
    end else if (diff_back[31:16] != 16'd0) begin
      rem_old = 16'hFFFF;
    end else begin
      rem_old = diff_back[15:0];
    end
  end

  // Backoff length: base shifted by the clamped attempt count, capped at the maximum
  assign shift   = (attempt_count > 8'(lbt_pkg::MAX_SHIFT)) ? lbt_pkg::MAX_SHIFT
                                                            : attempt_count[2:0];
  assign len_raw = lbt_pkg::BASE_BACKOFF_MS << shift;
  assign len     = (len_raw > backoff_cap) ? backoff_cap : len_raw;

  // Signal strength against threshold
  assign rssi_level = $signed({2'b00, s1_rssi} - lbt_pkg::RSSI_OFFSET);
  assign thr        = $signed({{2{rssi_limit[7]}}, rssi_limit});
  assign rssi_busy  = rssi_level > thr;

  // Judge the channel and work out the next state
  always_comb begin
    status_next           = lbt_pkg::ST_CLEAR;
    abort_next            = 1'b0;
    busy                  = 1'b0;
    backoff_deadline_next = backoff_deadline;
    attempt_count_next    = attempt_count;
    backoff_armed_next    = backoff_armed;
    if (s1_command == lbt_pkg::CMD_QUERY) begin
      status_next = lbt_pkg::ST_QUERY;
    end else if (!lbt_enable) begin
      status_next = lbt_pkg::ST_DISABLED;
    end else if (rem_old != 16'd0) begin
      status_next = lbt_pkg::ST_BACKOFF;
      abort_next  = 1'b1;
    end else begin
      if (detect_len != 8'd0 && s1_cad == lbt_pkg::CAD_DETECTED) begin
        busy = 1'b1;
      end else if (detect_len != 8'd0 && s1_cad != lbt_pkg::CAD_CLEAR) begin
        status_next = lbt_pkg::ST_ERROR;
      end else if (!s1_rx_ok) begin
        status_next = lbt_pkg::ST_ERROR;
      end else if (rssi_busy) begin
        busy = 1'b1;
      end
      if (busy) begin
        status_next           = lbt_pkg::ST_BUSY;
        abort_next            = 1'b1;
        backoff_deadline_next = s1_now + {16'd0, len};
        backoff_armed_next    = 1'b1;
        if (attempt_count != lbt_pkg::ATTEMPT_LIMIT) begin
          attempt_count_next = attempt_count + 8'd1;
        end
      end else if (status_next == lbt_pkg::ST_CLEAR) begin
        backoff_deadline_next = 32'd0;
        attempt_count_next    = 8'd0;
        backoff_armed_next    = 1'b0;
      end
    end
  end

  // A fresh backoff leaves its full length; otherwise the old remainder stands
  assign remaining_next = busy ? len : rem_old;

  // Advance the backoff state as a transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_deadline <= 32'd0;
      attempt_count    <= 8'd0;
      backoff_armed    <= 1'b0;
    end else if (s1_move) begin
      backoff_deadline <= backoff_deadline_next;
      attempt_count    <= attempt_count_next;
      backoff_armed    <= backoff_armed_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status               <= status_next;
      backoff_remaining_ms <= remaining_next;
      tx_abort             <= abort_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/lbt_checker.sv -----
// Port-level checks of the listen-before-talk gate, bound to its top level.
`default_nettype none
module lbt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  status,
  input wire logic [15:0] backoff_remaining_ms,
  input wire logic        tx_abort
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(backoff_remaining_ms) && $stable(tx_abort))
    else $error("stalled result changed");

  // Drop any result after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // Abort only for busy or backoff
  a_abort_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tx_abort == ((status == lbt_pkg::ST_BUSY) ||
                                (status == lbt_pkg::ST_BACKOFF))))
    else $error("abort flag disagrees with status");

  // Clear and error leave no backoff; backoff always leaves some
  a_remaining_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == lbt_pkg::ST_CLEAR) || (status == lbt_pkg::ST_ERROR))
      |-> backoff_remaining_ms == 16'd0)
    else $error("remaining backoff after clear or error");

  a_backoff_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == lbt_pkg::ST_BACKOFF) |-> backoff_remaining_ms != 16'd0)
    else $error("backoff status with nothing remaining");

endmodule

bind listen_before_talk_backoff lbt_checker u_lbt_checker (
  .clk                  (clk),
  .rst                  (rst),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .status               (status),
  .backoff_remaining_ms (backoff_remaining_ms),
  .tx_abort             (tx_abort)
);
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the listen-before-talk backoff gate: directed and random traffic.
module tb_top;

  typedef struct packed {
    logic        command;
    logic [31:0] now_ms;
    logic [1:0]  cad_outcome;
    logic        rx_entry_ok;
    logic [7:0]  rssi_raw;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] remaining;
    logic        abort;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [31:0] now_ms = '0;
  logic [1:0]  cad_outcome = '0;
  logic        rx_entry_ok = 1'b0;
  logic [7:0]  rssi_raw = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] backoff_remaining_ms;
  logic        tx_abort;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  request_t requests_pending[$];
  verdict_t verdicts_due[$];
  request_t on_wire;
  verdict_t want;
  int       mismatches = 0;
  int       requests_issued = 0;
  int       results_seen = 0;
  int       send_gap_max = 4;
  int       stall_max = 4;
  int       send_wait = 0;
  int       stall_wait = 0;
  logic [31:0] clock_ms = '0;

  // Gate settings as last written
  logic              gate_on = lbt_pkg::RESET_LBT_ENABLE;
  logic signed [7:0] thresh_dbm = lbt_pkg::RESET_THRESHOLD;
  logic [15:0]       cap_ms = lbt_pkg::RESET_MAX_BACKOFF;
  logic [7:0]        cad_syms = lbt_pkg::RESET_CAD_SYMBOLS;

  // Backoff state of the gate
  logic [31:0] deadline = '0;
  logic [7:0]  attempts = '0;
  logic        armed = 1'b0;

  listen_before_talk_backoff i_dut (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .command              (command),
    .now_ms               (now_ms),
    .cad_outcome          (cad_outcome),
    .rx_entry_ok          (rx_entry_ok),
    .rssi_raw             (rssi_raw),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .status               (status),
    .backoff_remaining_ms (backoff_remaining_ms),
    .tx_abort             (tx_abort),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Milliseconds left before the armed deadline, saturated to 16 bits
  function automatic logic [15:0] ms_left(logic [31:0] at_ms);
    logic [31:0] diff;
    if (!armed) return '0;
    diff = at_ms - deadline;
    if (!diff[31]) return '0;
    diff = deadline - at_ms;
    return (diff > 32'h0000_FFFF) ? 16'hFFFF : diff[15:0];
  endfunction

  // Decide one request and advance the backoff state
  function automatic verdict_t gate_verdict(request_t rq);
    verdict_t    v;
    logic        busy;
    int          level_dbm;
    int          limit_dbm;
    int unsigned shift;
    logic [31:0] span;
    v.abort = 1'b0;
    busy = 1'b0;
    level_dbm = int'(rq.rssi_raw) - int'(lbt_pkg::RSSI_OFFSET);
    limit_dbm = int'(thresh_dbm);
    if (rq.command == lbt_pkg::CMD_QUERY) begin
      v.status = lbt_pkg::ST_QUERY;
    end else if (!gate_on) begin
      v.status = lbt_pkg::ST_DISABLED;
    end else if (ms_left(rq.now_ms) != 16'd0) begin
      v.status = lbt_pkg::ST_BACKOFF;
      v.abort = 1'b1;
    end else begin
      v.status = lbt_pkg::ST_CLEAR;
      if (cad_syms != 8'd0) begin
        if (rq.cad_outcome == lbt_pkg::CAD_DETECTED) busy = 1'b1;
        else if (rq.cad_outcome != lbt_pkg::CAD_CLEAR) v.status = lbt_pkg::ST_ERROR;
      end
      if (!busy && v.status != lbt_pkg::ST_ERROR) begin
        if (!rq.rx_entry_ok) v.status = lbt_pkg::ST_ERROR;
        else if (level_dbm > limit_dbm) busy = 1'b1;
      end
      if (busy) begin
        // arm an exponential backoff, capped
        shift = (attempts > 8'(lbt_pkg::MAX_SHIFT)) ? 32'(lbt_pkg::MAX_SHIFT)
                                                    : 32'(attempts);
        span = 32'(lbt_pkg::BASE_BACKOFF_MS) << shift;
        if (span > {16'd0, cap_ms}) span = {16'd0, cap_ms};
        deadline = rq.now_ms + span;
        armed = 1'b1;
        if (attempts < lbt_pkg::ATTEMPT_LIMIT) attempts++;
        v.status = lbt_pkg::ST_BUSY;
        v.abort = 1'b1;
      end else if (v.status == lbt_pkg::ST_CLEAR) begin
        deadline = '0;
        attempts = '0;
        armed = 1'b0;
      end
    end
    v.remaining = ms_left(rq.now_ms);
    return v;
  endfunction

  task automatic flag_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Request driver: present queued requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) verdicts_due.push_back(gate_verdict(on_wire));
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (requests_pending.size() > 0) begin
        on_wire = requests_pending.pop_front();
        command <= on_wire.command;
        now_ms <= on_wire.now_ms;
        cad_outcome <= on_wire.cad_outcome;
        rx_entry_ok <= on_wire.rx_entry_ok;
        rssi_raw <= on_wire.rssi_raw;
        in_valid <= 1'b1;
        send_wait = int'($urandom_range(0, send_gap_max));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each transaction with the oldest verdict, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (verdicts_due.size() == 0) begin
          flag_mismatch("result with no verdict waiting");
        end else begin
          want = verdicts_due.pop_front();
          if (status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
          if (backoff_remaining_ms !== want.remaining)
            flag_mismatch($sformatf("remaining %0d, expected %0d",
                                    backoff_remaining_ms, want.remaining));
          if (tx_abort !== want.abort)
            flag_mismatch($sformatf("tx_abort %0b, expected %0b", tx_abort, want.abort));
        end
        stall_wait = int'($urandom_range(0, stall_max));
      end
      out_stall <= (stall_wait > 0);
      if (stall_wait > 0) stall_wait--;
    end
  end

  task automatic queue_request(logic cmd, logic [31:0] at_ms, logic [1:0] cad, logic rx_ok,
                               logic [7:0] rssi);
    request_t rq;
    rq.command = cmd;
    rq.now_ms = at_ms;
    rq.cad_outcome = cad;
    rq.rx_entry_ok = rx_ok;
    rq.rssi_raw = rssi;
    requests_pending.push_back(rq);
    requests_issued++;
  endtask

  // Hold until every result is in, then let the pipeline settle
  task automatic wait_drained();
    while (results_seen != requests_issued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      lbt_pkg::REG_LBT_ENABLE:  gate_on = value[0];
      lbt_pkg::REG_RSSI_LIMIT:  thresh_dbm = value[7:0];
      lbt_pkg::REG_BACKOFF_CAP: cap_ms = value;
      lbt_pkg::REG_DETECT_LEN:  cad_syms = value[7:0];
      default: ;
    endcase
  endtask

  // Random traffic; lean_busy keeps the channel busy so the attempt count climbs
  task automatic random_traffic(int count, bit lean_busy);
    int         pick;
    int         level;
    logic       cmd;
    logic [1:0] cad;
    for (int k = 0; k < count; k++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 60) clock_ms += $urandom_range(0, 40);
      else if (pick < 85) clock_ms += $urandom_range(0, 700);
      else if (pick < 93) clock_ms = $urandom;
      else clock_ms -= $urandom_range(0, 300);
      cmd = ($urandom_range(0, 99) < 85) ? lbt_pkg::CMD_CHECK : lbt_pkg::CMD_QUERY;
      pick = int'($urandom_range(0, 99));
      if (pick < 60) cad = lbt_pkg::CAD_CLEAR;
      else if (pick < 80) cad = lbt_pkg::CAD_DETECTED;
      else if (pick < 90) cad = lbt_pkg::CAD_ERROR;
      else cad = lbt_pkg::CAD_TIMEOUT;
      if (lean_busy) begin
        level = ($urandom_range(0, 999) == 0) ? 0 : int'($urandom_range(30, 255));
      end else if ($urandom_range(0, 1) == 0) begin
        level = int'(thresh_dbm) + 147 + int'($urandom_range(0, 20));
        if (level < 0) level = 0;
        if (level > 255) level = 255;
      end else begin
        level = int'($urandom_range(0, 255));
      end
      queue_request(cmd, clock_ms, cad, $urandom_range(0, 9) != 0, level[7:0]);
    end
  endtask

  task automatic run_phase(logic on, logic [7:0] thr, logic [15:0] cap, logic [7:0] syms,
                           int count, bit lean_busy, int gap, int stall);
    wait_drained();
    write_reg(lbt_pkg::REG_LBT_ENABLE, 16'(on));
    write_reg(lbt_pkg::REG_RSSI_LIMIT, 16'(thr));
    write_reg(lbt_pkg::REG_BACKOFF_CAP, cap);
    write_reg(lbt_pkg::REG_DETECT_LEN, 16'(syms));
    send_gap_max = gap;
    stall_max = stall;
    random_traffic(count, lean_busy);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, threshold -90 dBm means busy above raw 67
    queue_request(lbt_pkg::CMD_QUERY, 32'd0, lbt_pkg::CAD_CLEAR, 1'b0, 8'd0);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1000, lbt_pkg::CAD_CLEAR, 1'b1, 8'd0);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1000, lbt_pkg::CAD_DETECTED, 1'b1, 8'd0);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1005, lbt_pkg::CAD_CLEAR, 1'b1, 8'd0);
    queue_request(lbt_pkg::CMD_QUERY, 32'd1005, lbt_pkg::CAD_TIMEOUT, 1'b1, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1010, lbt_pkg::CAD_CLEAR, 1'b1, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1030, lbt_pkg::CAD_ERROR, 1'b1, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1030, lbt_pkg::CAD_TIMEOUT, 1'b1, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1030, lbt_pkg::CAD_CLEAR, 1'b0, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1030, lbt_pkg::CAD_CLEAR, 1'b1, 8'd67);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1030, lbt_pkg::CAD_CLEAR, 1'b1, 8'd68);
    // time running backwards past the 16-bit range
    queue_request(lbt_pkg::CMD_CHECK, 32'hFFFF_0000, lbt_pkg::CAD_CLEAR, 1'b1, 8'd0);
    queue_request(lbt_pkg::CMD_QUERY, 32'h8000_0416, lbt_pkg::CAD_CLEAR, 1'b1, 8'd0);
    queue_request(lbt_pkg::CMD_QUERY, 32'hFFFF_FFFF, lbt_pkg::CAD_TIMEOUT, 1'b1, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1040, lbt_pkg::CAD_TIMEOUT, 1'b1, 8'hFF);
    queue_request(lbt_pkg::CMD_CHECK, 32'd1040, lbt_pkg::CAD_CLEAR, 1'b1, 8'd0);
    clock_ms = 32'd2000;
    random_traffic(150, 1'b0);

    // Sweep the settings, extremes included
    run_phase(1'b1, 8'(-90), 16'd500, 8'd4, 150, 1'b0, 0, 0);
    run_phase(1'b1, 8'h80, 16'd0, 8'd0, 400, 1'b1, 4, 0);
    run_phase(1'b0, 8'd127, 16'hFFFF, 8'd255, 100, 1'b0, 0, 4);
    run_phase(1'b1, 8'd127, 16'hFFFF, 8'd1, 150, 1'b0, 4, 4);
    run_phase(1'b1, 8'(-60), 16'd200, 8'd0, 150, 1'b0, 0, 0);
    run_phase(1'b1, 8'(-100), 16'd1000, 8'd8, 200, 1'b1, 4, 4);
    run_phase(1'b1, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
              8'($urandom_range(0, 255)), 150, 1'b0, 2, 3);
    run_phase(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
              16'($urandom_range(0, 700)), 8'($urandom_range(0, 255)), 150, 1'b0, 4, 1);
    run_phase(1'b1, 8'(-90), 16'd500, 8'd4, 150, 1'b0, 2, 2);

    wait_drained();
    repeat (10) @(posedge clk);
    if (verdicts_due.size() != 0)
      flag_mismatch($sformatf("%0d verdicts never matched", verdicts_due.size()));
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
